// ===== sv/sfwbct_pkg.sv =====
package sfwbct_pkg;

	localparam int TAB_W   = 14;
	localparam int POS_W   = 40;
	localparam int OFF_W   = 16;
	localparam int SETO_W  = 10;
	localparam int WAYS    = 4;
	localparam int WAY_W   = 2;
	localparam int HASH_W  = 16;
	localparam int IN_W    = 56;
	localparam int OUT_W   = 32;

	localparam logic [9:0] HASH_KA [WAYS] = '{10'd123, 10'd179, 10'd671, 10'd773};
	localparam logic [9:0] HASH_KB [WAYS] = '{10'd321, 10'd557, 10'd409, 10'd187};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	// Low bits of the weighted sum; enough for any set count up to 2^16.
	function automatic logic [HASH_W-1:0] way_hash(input logic [WAY_W-1:0] w,
		input logic [TAB_W-1:0] t, input logic [HASH_W-1:0] b);
		logic [31:0] p;
		p = 32'(HASH_KA[w]) * 32'(t) + 32'(HASH_KB[w]) * 32'(b);
		return p[HASH_W-1:0];
	endfunction

endpackage

// ===== sv/skewed_four_way_block_cache_tags.sv =====
// Tag engine of a four-way skewed-associative block cache. Each request word
// names a table and a byte position; the result word gives hit/miss, the way
// that holds (or now owns) the block, its set in that way and the byte offset
// inside the block, so an external filler can load the block on a miss. When
// a request is accepted the four per-way tag RAMs are read at their hashed
// sets; in the lookup state the tags are compared, the victim picked and, on
// a miss, the new tag written back. A result waits in an output register, so
// the lookup only stalls when that register is still full and not being taken.
// After reset the block runs a clearing pass over all SETS entries of the tag
// RAMs before it takes the first request.
module skewed_four_way_block_cache_tags #(
	parameter int BLOCK_BYTES = 65536,
	parameter int SETS        = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// table_id[13:0], position[53:14], zero fill
	input  logic [sfwbct_pkg::IN_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// way[1:0], set_index[11:2], block_offset[27:12], zero fill
	output logic [sfwbct_pkg::OUT_W-1:0] m_tdata,
	// hit
	output logic                        m_tuser
);

	import sfwbct_pkg::*;

	localparam int OFF_BITS = $clog2(BLOCK_BYTES);
	localparam int BLK_W    = POS_W - OFF_BITS;
	localparam int TAG_W    = TAB_W + BLK_W;
	localparam int ENT_W    = TAG_W + 1;
	localparam int SET_W    = $clog2(SETS);

	state_t state_q, state_d;

	logic                s_acc;
	logic                commit;
	logic                clr_we;
	logic [SET_W-1:0]    clr_idx_q;

	logic [TAB_W-1:0]    tab_in;
	logic [BLK_W-1:0]    blk_in;
	logic [SET_W-1:0]    h_in [WAYS];

	logic [TAG_W-1:0]    tag_s1;
	logic [OFF_W-1:0]    off_s1;
	logic [SET_W-1:0]    h_s1 [WAYS];

	logic [ENT_W-1:0]    rd_ent [WAYS];
	logic                ram_we [WAYS];
	logic [SET_W-1:0]    ram_waddr [WAYS];
	logic [ENT_W-1:0]    ram_wdata;

	logic                hit_c;
	logic [WAY_W-1:0]    hit_way_c;
	logic                any_empty_c;
	logic [WAY_W-1:0]    empty_way_c;
	logic [WAY_W-1:0]    victim_c;
	logic [WAY_W-1:0]    res_way_c;
	logic [HASH_W-1:0]   res_set_c;
	logic [31:0]         miss_q;
	logic [31:0]         miss_n;

	logic                out_valid_q;
	logic                hit_q;
	logic [WAY_W-1:0]    way_q;
	logic [SETO_W-1:0]   set_q;
	logic [OFF_W-1:0]    off_q;

	assign tab_in = s_tdata[TAB_W-1:0];
	assign blk_in = s_tdata[TAB_W+POS_W-1:TAB_W+OFF_BITS];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if (commit) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		clr_we   = 1'b0;
		commit   = 1'b0;
		case (state_q)
			ST_CLEAR: clr_we = 1'b1;
			ST_IDLE:  s_tready = 1'b1;
			ST_LOOK:  commit = !out_valid_q || m_tready;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign s_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_we) clr_idx_q <= clr_idx_q + SET_W'(1);
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			tag_s1 <= {tab_in, blk_in};
			off_s1 <= OFF_W'(s_tdata[TAB_W+OFF_BITS-1:TAB_W]);
			for (int w = 0; w < WAYS; w++) begin
				h_s1[w] <= h_in[w];
			end
		end
	end

	assign ram_wdata = clr_we ? '0 : {1'b1, tag_s1};

	for (genvar g = 0; g < WAYS; g++) begin : g_way
		logic [HASH_W-1:0] h_full;

		assign h_full       = way_hash(WAY_W'(g), tab_in, blk_in[HASH_W-1:0]);
		assign h_in[g]      = h_full[SET_W-1:0];
		assign ram_we[g]    = clr_we || (commit && !hit_c && victim_c == WAY_W'(g));
		assign ram_waddr[g] = clr_we ? clr_idx_q : h_s1[g];

		sfwbct_tag_ram #(
			.ADDR_W(SET_W),
			.DATA_W(ENT_W)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[g]),
			.waddr (ram_waddr[g]),
			.wdata (ram_wdata),
			.re    (s_acc),
			.raddr (h_in[g]),
			.rdata (rd_ent[g])
		);
	end

	// compare and victim choice
	always_comb begin
		hit_c       = 1'b0;
		hit_way_c   = '0;
		any_empty_c = 1'b0;
		empty_way_c = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_ent[w][ENT_W-1] && rd_ent[w][TAG_W-1:0] == tag_s1) begin
				hit_c     = 1'b1;
				hit_way_c = WAY_W'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!rd_ent[w][ENT_W-1]) begin
				any_empty_c = 1'b1;
				empty_way_c = WAY_W'(w);
			end
		end
	end

	// sum of (count >> i), i < 16, mod 4: popcount of the low bits plus
	// twice the parity of the bits one up
	assign miss_n   = miss_q + 32'd1;
	assign victim_c = any_empty_c ? empty_way_c :
		WAY_W'($countones(miss_n[15:0])) + {^miss_n[16:1], 1'b0};

	assign res_way_c = hit_c ? hit_way_c : victim_c;
	assign res_set_c = HASH_W'(h_s1[res_way_c]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit && !hit_c) miss_q <= miss_n;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q <= hit_c;
			way_q <= res_way_c;
			set_q <= res_set_c[SETO_W-1:0];
			off_q <= off_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {(OUT_W - WAY_W - SETO_W - OFF_W)'(0), off_q, set_q, way_q};

endmodule

// ===== sv/sfwbct_tag_ram.sv =====
module sfwbct_tag_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 39
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/sfwbct_checker.sv =====
module sfwbct_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [sfwbct_pkg::IN_W-1:0]  s_tdata,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [sfwbct_pkg::OUT_W-1:0] m_tdata,
	input logic                         m_tuser
);

	import sfwbct_pkg::*;

	// low byte of the last accepted position; a block size of 256 bytes or more keeps it
	logic [7:0] last_pos_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) last_pos_q <= s_tdata[TAB_W+7:TAB_W];
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while one is still in lookup");

	a_offset_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (!$past(m_tvalid) || $past(m_tready)) |->
			m_tdata[19:12] == last_pos_q)
		else $error("block offset does not match the request");

endmodule

bind skewed_four_way_block_cache_tags sfwbct_checker u_sfwbct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
